// ----- rtl/ctok_pkg.sv -----
package ctok_pkg;

    // Longest identifier or number that is counted exactly.
    localparam int MAX_TOKEN_CHARS = 63;
    // Width of the running byte offset.
    localparam int POSITION_BITS   = 24;

    // Run length counts one past the limit so that an over-long identifier is seen.
    localparam int LEN_W   = $clog2(MAX_TOKEN_CHARS + 2);
    localparam int START_W = 24;
    localparam int VALUE_W = 32;
    localparam int TLEN_W  = 6;
    localparam logic [TLEN_W-1:0] LEN_SAT = '1;

    localparam int KW_COUNT      = 5;
    localparam int KW_TEXT_DEPTH = 8;
    localparam int KW_IDX_W      = $clog2(KW_TEXT_DEPTH);

    localparam int OUTQ_DEPTH = 4;
    localparam int OUTQ_PTR_W = $clog2(OUTQ_DEPTH);
    localparam int OUTQ_CNT_W = $clog2(OUTQ_DEPTH + 1);

    typedef enum logic [4:0] {
        KIND_EOF      = 5'd0,
        KIND_INT      = 5'd1,
        KIND_RETURN   = 5'd2,
        KIND_IF       = 5'd3,
        KIND_ELSE     = 5'd4,
        KIND_WHILE    = 5'd5,
        KIND_IDENT    = 5'd6,
        KIND_NUMBER   = 5'd7,
        KIND_LPAREN   = 5'd8,
        KIND_RPAREN   = 5'd9,
        KIND_LBRACE   = 5'd10,
        KIND_RBRACE   = 5'd11,
        KIND_SEMI     = 5'd12,
        KIND_COMMA    = 5'd13,
        KIND_ASSIGN   = 5'd14,
        KIND_PLUS     = 5'd15,
        KIND_MINUS    = 5'd16,
        KIND_STAR     = 5'd17,
        KIND_SLASH    = 5'd18,
        KIND_EQ       = 5'd19,
        KIND_NE       = 5'd20,
        KIND_LT       = 5'd21,
        KIND_LE       = 5'd22,
        KIND_GT       = 5'd23,
        KIND_GE       = 5'd24,
        KIND_ANDAND   = 5'd25,
        KIND_OROR     = 5'd26
    } t_kind;

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_IDENT,
        MODE_NUMBER,
        MODE_COMMENT
    } t_mode;

    typedef enum logic [2:0] {
        PEND_NONE    = 3'd0,
        PEND_SLASH   = 3'd1,
        PEND_ASSIGN  = 3'd2,
        PEND_BANG    = 3'd3,
        PEND_LESS    = 3'd4,
        PEND_GREATER = 3'd5,
        PEND_AMP     = 3'd6,
        PEND_BAR     = 3'd7
    } t_pend;

    typedef struct packed {
        logic [7:0] ch;
        logic       end_of_text;
    } t_in_item;

    typedef struct packed {
        t_kind               kind;
        logic [VALUE_W-1:0]  number_value;
        logic [START_W-1:0]  token_start;
        logic [TLEN_W-1:0]   token_length;
        logic                overflow;
        logic                last;
    } t_out_item;

    // Tokens produced by one byte, in order; count is 0, 1 or 2.
    typedef struct packed {
        logic [1:0] count;
        t_out_item  tok0;
        t_out_item  tok1;
    } t_scan_res;

    localparam int unsigned KW_LEN [KW_COUNT] = '{3, 6, 2, 4, 5};

    localparam t_kind KW_KIND [KW_COUNT] = '{
        KIND_INT, KIND_RETURN, KIND_IF, KIND_ELSE, KIND_WHILE
    };

    localparam logic [7:0] KW_TEXT [KW_COUNT][KW_TEXT_DEPTH] = '{
        '{"i", "n", "t", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"r", "e", "t", "u", "r", "n", 8'h00, 8'h00},
        '{"i", "f", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"e", "l", "s", "e", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"w", "h", "i", "l", "e", 8'h00, 8'h00, 8'h00}
    };

endpackage

// ----- rtl/ctok_scan.sv -----
module ctok_scan (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_fire,
    input  ctok_pkg::t_in_item  i_item,
    output ctok_pkg::t_scan_res o_res
);
    import ctok_pkg::*;

    localparam logic [7:0] CH_SLASH   = "/";
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_EQUAL   = "=";
    localparam logic [7:0] CH_AMP     = "&";
    localparam logic [7:0] CH_BAR     = "|";
    localparam logic [7:0] CH_UNDER   = "_";

    t_mode                    r_mode,  n_mode;
    t_pend                    r_pend,  n_pend;
    logic [KW_COUNT-1:0]      r_cand,  n_cand;
    logic [LEN_W-1:0]         r_len,   n_len;
    logic [VALUE_W-1:0]       r_acc,   n_acc;
    logic                     r_ovf,   n_ovf;
    logic [POSITION_BITS-1:0] r_start, n_start;
    logic [POSITION_BITS-1:0] r_pos,   n_pos;

    logic [7:0] c;
    logic       eot;
    logic       is_letter, is_digit;
    logic       pend_active, pair_slash, pair_eq, pair_amp, pair_bar, pair_hit;
    logic       in_comment, ident_cont, num_cont, pend_break, run_break, do_idle;

    t_kind idle_kind;
    t_pend idle_pend;

    logic [LEN_W-1:0]    base_len, grown_len;
    logic                base_ovf, len_over;
    logic [KW_COUNT-1:0] base_cand, upd_cand;
    logic [VALUE_W-1:0]  base_acc;
    logic [VALUE_W+3:0]  acc_x10;
    logic [3:0]          digit;

    t_kind     run_kind, pend_kind, pair_kind;
    logic      run_tok_valid, pend_tok_valid, idle_tok_valid;
    t_out_item run_tok, pend_tok, pair_tok, idle_tok, eof_tok;
    t_out_item tok_a, tok_b;
    logic      valid_a, valid_b;

    function automatic t_out_item make_tok(
        input t_kind                    kind,
        input logic [VALUE_W-1:0]       value,
        input logic [POSITION_BITS-1:0] start,
        input logic [TLEN_W-1:0]        length,
        input logic                     ovf
    );
        t_out_item t;
        t.kind         = kind;
        t.number_value = value;
        t.token_start  = START_W'(start);
        t.token_length = length;
        t.overflow     = ovf;
        t.last         = 1'b0;
        return t;
    endfunction

    // ---------------------------------------------------------------- decode
    assign c   = i_item.ch;
    assign eot = i_item.end_of_text;

    assign is_letter = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || (c == CH_UNDER);
    assign is_digit  = (c >= "0" && c <= "9");

    assign pend_active = (r_pend != PEND_NONE);
    assign pair_slash  = (r_pend == PEND_SLASH) && (c == CH_SLASH);
    assign pair_eq     = (c == CH_EQUAL) && (r_pend == PEND_ASSIGN || r_pend == PEND_BANG ||
                                             r_pend == PEND_LESS || r_pend == PEND_GREATER);
    assign pair_amp    = (r_pend == PEND_AMP) && (c == CH_AMP);
    assign pair_bar    = (r_pend == PEND_BAR) && (c == CH_BAR);
    assign pair_hit    = pair_eq || pair_amp || pair_bar;

    // A pending operator always sits in idle mode, so these paths are exclusive.
    assign in_comment = !pend_active && (r_mode == MODE_COMMENT);
    assign ident_cont = !pend_active && (r_mode == MODE_IDENT) && (is_letter || is_digit);
    assign num_cont   = !pend_active && (r_mode == MODE_NUMBER) && is_digit;
    assign pend_break = pend_active && !pair_slash && !pair_hit;
    assign run_break  = !pend_active && !in_comment && !ident_cont && !num_cont;
    assign do_idle    = pend_break || run_break;

    always_comb begin
        idle_kind = KIND_EOF;
        idle_pend = PEND_NONE;
        case (c)
            "(":     idle_kind = KIND_LPAREN;
            ")":     idle_kind = KIND_RPAREN;
            "{":     idle_kind = KIND_LBRACE;
            "}":     idle_kind = KIND_RBRACE;
            ";":     idle_kind = KIND_SEMI;
            ",":     idle_kind = KIND_COMMA;
            "+":     idle_kind = KIND_PLUS;
            "-":     idle_kind = KIND_MINUS;
            "*":     idle_kind = KIND_STAR;
            "/":     idle_pend = PEND_SLASH;
            "=":     idle_pend = PEND_ASSIGN;
            "!":     idle_pend = PEND_BANG;
            "<":     idle_pend = PEND_LESS;
            ">":     idle_pend = PEND_GREATER;
            "&":     idle_pend = PEND_AMP;
            "|":     idle_pend = PEND_BAR;
            default: idle_kind = KIND_EOF;
        endcase
    end

    // ------------------------------------------------------------ run update
    // A new run starts from cleared state; a continued run starts from the registers.
    assign base_len  = do_idle ? '0 : r_len;
    assign base_ovf  = do_idle ? 1'b0 : r_ovf;
    assign base_cand = do_idle ? '1 : r_cand;
    assign base_acc  = do_idle ? '0 : r_acc;

    assign grown_len = (32'(base_len) <= MAX_TOKEN_CHARS) ? base_len + LEN_W'(1) : base_len;
    assign len_over  = (32'(grown_len) > MAX_TOKEN_CHARS);

    always_comb begin
        for (int k = 0; k < KW_COUNT; k++) begin
            upd_cand[k] = base_cand[k] && (32'(base_len) < KW_LEN[k]) &&
                          (KW_TEXT[k][base_len[KW_IDX_W-1:0]] == c);
        end
    end

    assign digit   = c[3:0];
    assign acc_x10 = ({4'b0, base_acc} << 3) + ({4'b0, base_acc} << 1) + (VALUE_W + 4)'(digit);

    // ---------------------------------------------------------- next state
    always_comb begin
        n_mode  = r_mode;
        n_pend  = r_pend;
        n_cand  = r_cand;
        n_len   = r_len;
        n_acc   = r_acc;
        n_ovf   = r_ovf;
        n_start = r_start;
        n_pos   = r_pos;
        if (eot) begin
            n_mode  = MODE_IDLE;
            n_pend  = PEND_NONE;
            n_cand  = '1;
            n_len   = '0;
            n_acc   = '0;
            n_ovf   = 1'b0;
            n_start = '0;
            n_pos   = '0;
        end else begin
            n_pos = r_pos + POSITION_BITS'(1);
            if (pend_active) begin
                n_pend = PEND_NONE;
            end
            if (pair_slash) begin
                n_mode = MODE_COMMENT;
            end
            if (in_comment && c == CH_NEWLINE) begin
                n_mode = MODE_IDLE;
            end
            if (run_break) begin
                n_mode = MODE_IDLE;
            end
            if (ident_cont || (do_idle && is_letter)) begin
                n_mode = MODE_IDENT;
                n_cand = upd_cand;
                n_len  = grown_len;
                n_ovf  = base_ovf || len_over;
                n_acc  = base_acc;
            end
            if (num_cont || (do_idle && is_digit)) begin
                n_mode = MODE_NUMBER;
                n_len  = grown_len;
                n_ovf  = base_ovf || (|acc_x10[VALUE_W+3:VALUE_W]);
                n_acc  = acc_x10[VALUE_W-1:0];
            end
            if (do_idle && (is_letter || is_digit)) begin
                n_start = r_pos;
            end
            if (do_idle && idle_pend != PEND_NONE) begin
                n_pend  = idle_pend;
                n_start = r_pos;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_IDLE;
            r_pend  <= PEND_NONE;
            r_cand  <= '1;
            r_len   <= '0;
            r_acc   <= '0;
            r_ovf   <= 1'b0;
            r_start <= '0;
            r_pos   <= '0;
        end else if (i_fire) begin
            r_mode  <= n_mode;
            r_pend  <= n_pend;
            r_cand  <= n_cand;
            r_len   <= n_len;
            r_acc   <= n_acc;
            r_ovf   <= n_ovf;
            r_start <= n_start;
            r_pos   <= n_pos;
        end
    end

    // -------------------------------------------------------------- outputs
    always_comb begin
        run_kind = KIND_IDENT;
        for (int k = 0; k < KW_COUNT; k++) begin
            if (r_cand[k] && 32'(r_len) == KW_LEN[k]) begin
                run_kind = KW_KIND[k];
            end
        end
        if (r_mode == MODE_NUMBER) begin
            run_kind = KIND_NUMBER;
        end
    end

    always_comb begin
        pend_kind      = KIND_EOF;
        pend_tok_valid = 1'b1;
        pair_kind      = KIND_EOF;
        case (r_pend)
            PEND_SLASH:   pend_kind = KIND_SLASH;
            PEND_ASSIGN: begin
                pend_kind = KIND_ASSIGN;
                pair_kind = KIND_EQ;
            end
            PEND_BANG: begin
                pend_tok_valid = 1'b0;
                pair_kind      = KIND_NE;
            end
            PEND_LESS: begin
                pend_kind = KIND_LT;
                pair_kind = KIND_LE;
            end
            PEND_GREATER: begin
                pend_kind = KIND_GT;
                pair_kind = KIND_GE;
            end
            PEND_AMP: begin
                pend_tok_valid = 1'b0;
                pair_kind      = KIND_ANDAND;
            end
            PEND_BAR: begin
                pend_tok_valid = 1'b0;
                pair_kind      = KIND_OROR;
            end
            default:      pend_tok_valid = 1'b0;
        endcase
    end

    always_comb begin
        logic [TLEN_W-1:0] run_len_out;
        run_len_out    = (32'(r_len) > 32'(LEN_SAT)) ? LEN_SAT : TLEN_W'(r_len);
        run_tok_valid  = (r_mode == MODE_IDENT) || (r_mode == MODE_NUMBER);
        idle_tok_valid = do_idle && (idle_kind != KIND_EOF);

        run_tok  = make_tok(run_kind, (r_mode == MODE_NUMBER) ? r_acc : '0, r_start,
                            run_len_out, r_ovf);
        pend_tok = make_tok(pend_kind, '0, r_start, TLEN_W'(1), 1'b0);
        pair_tok = make_tok(pair_kind, '0, r_start, TLEN_W'(2), 1'b0);
        idle_tok = make_tok(idle_kind, '0, r_pos, TLEN_W'(1), 1'b0);
        eof_tok  = make_tok(KIND_EOF, '0, r_pos, '0, 1'b0);

        tok_a   = run_tok;
        tok_b   = idle_tok;
        valid_a = 1'b0;
        valid_b = 1'b0;
        if (eot) begin
            // A run and a pending operator never coexist, so at most one is flushed.
            tok_a   = run_tok_valid ? run_tok : pend_tok;
            valid_a = run_tok_valid || pend_tok_valid;
            tok_b   = eof_tok;
            valid_b = 1'b1;
        end else if (pair_hit) begin
            tok_a   = pair_tok;
            valid_a = 1'b1;
        end else if (pend_break) begin
            tok_a   = pend_tok;
            valid_a = pend_tok_valid;
            valid_b = idle_tok_valid;
        end else if (run_break) begin
            valid_a = run_tok_valid;
            valid_b = idle_tok_valid;
        end

        o_res.tok0 = valid_a ? tok_a : tok_b;
        o_res.tok1 = tok_b;
        o_res.tok1.last = 1'b1;
        o_res.count = 2'(valid_a) + 2'(valid_b);
        o_res.tok0.last = !(valid_a && valid_b);
    end

endmodule

// ----- rtl/ctok_outq.sv -----
module ctok_outq (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push_en,
    input  ctok_pkg::t_scan_res i_push,
    output logic                o_room,
    output logic                o_valid,
    input  logic                i_ready,
    output ctok_pkg::t_out_item o_data
);
    import ctok_pkg::*;

    t_out_item               r_q [OUTQ_DEPTH];
    logic [OUTQ_PTR_W-1:0]   r_rd, n_rd;
    logic [OUTQ_PTR_W-1:0]   r_wr, n_wr;
    logic [OUTQ_CNT_W-1:0]   r_cnt, n_cnt;
    logic [OUTQ_CNT_W-1:0]   push_n;
    logic                    pop;

    assign o_valid = (r_cnt != '0);
    assign o_data  = r_q[r_rd];
    // Room for the largest burst one byte can produce.
    assign o_room  = (32'(r_cnt) <= OUTQ_DEPTH - 2);
    assign pop     = o_valid && i_ready;
    assign push_n  = i_push_en ? OUTQ_CNT_W'(i_push.count) : '0;

    always_comb begin
        n_rd  = pop ? r_rd + OUTQ_PTR_W'(1) : r_rd;
        n_wr  = r_wr + OUTQ_PTR_W'(push_n);
        n_cnt = r_cnt + push_n - OUTQ_CNT_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd  <= '0;
            r_wr  <= '0;
            r_cnt <= '0;
        end else begin
            r_rd  <= n_rd;
            r_wr  <= n_wr;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_n != '0) begin
            r_q[r_wr] <= i_push.tok0;
        end
        if (push_n == OUTQ_CNT_W'(2)) begin
            r_q[r_wr + OUTQ_PTR_W'(1)] <= i_push.tok1;
        end
    end

endmodule

// ----- rtl/c_subset_tokenizer.sv -----
// Byte-serial lexer for a small C subset. One source byte (or an end-of-text
// marker) is taken per transfer on the input channel and can be taken in every
// cycle while the result queue has room. The byte is registered at the input;
// the tokens it completes go into the result queue and leave on the output
// channel, one per transfer. A byte finishes at most two tokens: a four-entry
// result queue absorbs them, so the sustained rate is one byte per cycle as
// long as most bytes yield no more than one token and the output is ready.
// Operators that may take a second character are held until the next byte.
// End of text flushes what is held, emits an EOF token and resets the lexer.
module c_subset_tokenizer (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  ctok_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output ctok_pkg::t_out_item o_out_data
);
    import ctok_pkg::*;

    logic      r_in_valid, n_in_valid;
    t_in_item  r_in;
    logic      fire;
    logic      room;
    t_scan_res scan_res;

    assign fire       = r_in_valid && room;
    assign o_in_ready = !r_in_valid || fire;

    always_comb begin
        n_in_valid = r_in_valid;
        if (o_in_ready) begin
            n_in_valid = i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_data;
        end
    end

    ctok_scan u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_item  (r_in),
        .o_res   (scan_res)
    );

    ctok_outq u_outq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push_en (fire),
        .i_push    (scan_res),
        .o_room    (room),
        .o_valid   (o_out_valid),
        .i_ready   (i_out_ready),
        .o_data    (o_out_data)
    );

    // An EOF token always closes the burst of its byte.
    a_eof_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.kind == KIND_EOF |-> o_out_data.last)
        else $error("EOF token without last");

    // A two-token burst marks only its second token as last.
    a_burst_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && scan_res.count == 2'd2 |-> !scan_res.tok0.last && scan_res.tok1.last)
        else $error("two-token burst has wrong last marking");

    // An end-of-text byte always produces the EOF token.
    a_eot_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && r_in.end_of_text |-> scan_res.count != 2'd0)
        else $error("end of text produced no token");

    // Only number tokens carry a value.
    a_value_number_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.kind != KIND_NUMBER |-> o_out_data.number_value == '0)
        else $error("non-number token carries a value");

endmodule

// ----- tb/ctok_token_checker.sv -----
`timescale 1ns / 1ps

module ctok_token_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_ready,
    input  ctok_pkg::t_in_item  i_in_data,
    input  logic                i_out_valid,
    input  logic                i_out_ready,
    input  ctok_pkg::t_out_item i_out_data,
    output int                  o_fail_count,
    output int                  o_tokens_due,
    output int                  o_tokens_checked
);
    import ctok_pkg::*;

    string kw_word [KW_COUNT] = '{"int", "return", "if", "else", "while"};
    t_kind kw_kind [KW_COUNT] = '{KIND_INT, KIND_RETURN, KIND_IF, KIND_ELSE, KIND_WHILE};

    // Lexer state as seen from outside.
    t_mode                scan_mode;
    t_pend                held_op;
    logic [KW_COUNT-1:0]  kw_alive;
    int unsigned          run_len;
    logic [VALUE_W-1:0]   num_acc;
    logic                 run_ovf;
    logic [START_W-1:0]   run_start;
    logic [START_W-1:0]   byte_pos;

    t_out_item tokens_due [$];
    t_out_item step_toks [$];
    int        misses;
    int        checked;

    function automatic bit is_letter(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

    function automatic bit is_digit(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic void clear_state();
        scan_mode = MODE_IDLE;
        held_op   = PEND_NONE;
        kw_alive  = '1;
        run_len   = 0;
        num_acc   = '0;
        run_ovf   = 1'b0;
        run_start = '0;
        byte_pos  = '0;
    endfunction

    function automatic void emit_token(t_kind kind, logic [VALUE_W-1:0] value,
                                       logic [START_W-1:0] start, int unsigned len,
                                       logic ovf);
        t_out_item tok;
        if (step_toks.size() >= 2) begin
            return;
        end
        tok.kind         = kind;
        tok.number_value = value;
        tok.token_start  = start;
        tok.token_length = (len >= LEN_SAT) ? LEN_SAT : TLEN_W'(len);
        tok.overflow     = ovf;
        tok.last         = 1'b0;
        step_toks.push_back(tok);
    endfunction

    function automatic void grow_run();
        if (run_len <= MAX_TOKEN_CHARS) begin
            run_len++;
        end
    endfunction

    function automatic void take_ident_char(logic [7:0] c);
        for (int k = 0; k < KW_COUNT; k++) begin
            if (run_len >= kw_word[k].len() || kw_word[k][run_len] != c) begin
                kw_alive[k] = 1'b0;
            end
        end
        grow_run();
        if (run_len > MAX_TOKEN_CHARS) begin
            run_ovf = 1'b1;
        end
    endfunction

    function automatic void take_digit(logic [7:0] c);
        logic [35:0] sum;
        sum = 36'(num_acc) * 36'd10 + 36'(c - "0");
        if (sum[35:32] != '0) begin
            run_ovf = 1'b1;
        end
        num_acc = sum[31:0];
        grow_run();
    endfunction

    function automatic void flush_run();
        t_kind kind;
        if (scan_mode == MODE_IDENT) begin
            kind = KIND_IDENT;
            for (int k = 0; k < KW_COUNT; k++) begin
                if (kw_alive[k] && run_len == kw_word[k].len()) begin
                    kind = kw_kind[k];
                end
            end
            emit_token(kind, '0, run_start, run_len, run_ovf);
        end else if (scan_mode == MODE_NUMBER) begin
            emit_token(KIND_NUMBER, num_acc, run_start, run_len, run_ovf);
        end
        scan_mode = MODE_IDLE;
    endfunction

    // A held operator that found no partner stands alone; bang, ampersand and bar vanish.
    function automatic void flush_held(t_pend p);
        case (p)
            PEND_SLASH:   emit_token(KIND_SLASH, '0, run_start, 1, 1'b0);
            PEND_ASSIGN:  emit_token(KIND_ASSIGN, '0, run_start, 1, 1'b0);
            PEND_LESS:    emit_token(KIND_LT, '0, run_start, 1, 1'b0);
            PEND_GREATER: emit_token(KIND_GT, '0, run_start, 1, 1'b0);
            default: ;
        endcase
    endfunction

    function automatic void start_from_idle(logic [7:0] c, logic [START_W-1:0] pos);
        t_pend hold;
        hold = PEND_NONE;
        if (is_letter(c)) begin
            scan_mode = MODE_IDENT;
            run_start = pos;
            run_len   = 0;
            run_ovf   = 1'b0;
            kw_alive  = '1;
            num_acc   = '0;
            take_ident_char(c);
            return;
        end
        if (is_digit(c)) begin
            scan_mode = MODE_NUMBER;
            run_start = pos;
            run_len   = 0;
            run_ovf   = 1'b0;
            num_acc   = '0;
            take_digit(c);
            return;
        end
        case (c)
            "(": emit_token(KIND_LPAREN, '0, pos, 1, 1'b0);
            ")": emit_token(KIND_RPAREN, '0, pos, 1, 1'b0);
            "{": emit_token(KIND_LBRACE, '0, pos, 1, 1'b0);
            "}": emit_token(KIND_RBRACE, '0, pos, 1, 1'b0);
            ";": emit_token(KIND_SEMI, '0, pos, 1, 1'b0);
            ",": emit_token(KIND_COMMA, '0, pos, 1, 1'b0);
            "+": emit_token(KIND_PLUS, '0, pos, 1, 1'b0);
            "-": emit_token(KIND_MINUS, '0, pos, 1, 1'b0);
            "*": emit_token(KIND_STAR, '0, pos, 1, 1'b0);
            "/": hold = PEND_SLASH;
            "=": hold = PEND_ASSIGN;
            "!": hold = PEND_BANG;
            "<": hold = PEND_LESS;
            ">": hold = PEND_GREATER;
            "&": hold = PEND_AMP;
            "|": hold = PEND_BAR;
            default: ;
        endcase
        if (hold != PEND_NONE) begin
            held_op   = hold;
            run_start = pos;
        end
    endfunction

    // Works out the tokens that one accepted item completes and queues them.
    function automatic void lex_item(t_in_item item);
        logic [7:0]         c;
        logic [START_W-1:0] pos;
        t_pend              p;
        t_kind              pair;
        c = item.ch;
        step_toks.delete();
        if (item.end_of_text) begin
            flush_run();
            p       = held_op;
            held_op = PEND_NONE;
            flush_held(p);
            emit_token(KIND_EOF, '0, byte_pos, 0, 1'b0);
            clear_state();
        end else begin
            pos      = byte_pos;
            byte_pos = byte_pos + 1'b1;
            if (held_op != PEND_NONE) begin
                p       = held_op;
                held_op = PEND_NONE;
                if (p == PEND_SLASH && c == "/") begin
                    scan_mode = MODE_COMMENT;
                end else if (c == "=" && (p == PEND_ASSIGN || p == PEND_BANG ||
                                          p == PEND_LESS || p == PEND_GREATER)) begin
                    case (p)
                        PEND_ASSIGN: pair = KIND_EQ;
                        PEND_BANG:   pair = KIND_NE;
                        PEND_LESS:   pair = KIND_LE;
                        default:     pair = KIND_GE;
                    endcase
                    emit_token(pair, '0, run_start, 2, 1'b0);
                end else if (c == "&" && p == PEND_AMP) begin
                    emit_token(KIND_ANDAND, '0, run_start, 2, 1'b0);
                end else if (c == "|" && p == PEND_BAR) begin
                    emit_token(KIND_OROR, '0, run_start, 2, 1'b0);
                end else begin
                    flush_held(p);
                    start_from_idle(c, pos);
                end
            end else if (scan_mode == MODE_COMMENT) begin
                if (c == "\n") begin
                    scan_mode = MODE_IDLE;
                end
            end else if (scan_mode == MODE_IDENT && (is_letter(c) || is_digit(c))) begin
                take_ident_char(c);
            end else if (scan_mode == MODE_NUMBER && is_digit(c)) begin
                take_digit(c);
            end else begin
                flush_run();
                start_from_idle(c, pos);
            end
        end
        for (int i = 0; i < step_toks.size(); i++) begin
            if (i == step_toks.size() - 1) begin
                step_toks[i].last = 1'b1;
            end
            tokens_due.push_back(step_toks[i]);
        end
    endfunction

    function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $display("%0t: token %0d %s expected 0x%0h, got 0x%0h",
                     $time, checked, field, want, got);
            misses++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            clear_state();
            tokens_due.delete();
            misses  = 0;
            checked = 0;
        end else begin
            if (i_in_valid && i_in_ready) begin
                lex_item(i_in_data);
            end
            if (i_out_valid && i_out_ready) begin
                if (tokens_due.size() == 0) begin
                    $display("%0t: token %0d expected none, got kind %0d start %0d",
                             $time, checked, i_out_data.kind, i_out_data.token_start);
                    misses++;
                end else begin
                    want = tokens_due.pop_front();
                    check_field("kind", want.kind, i_out_data.kind);
                    check_field("number_value", want.number_value, i_out_data.number_value);
                    check_field("token_start", want.token_start, i_out_data.token_start);
                    check_field("token_length", want.token_length, i_out_data.token_length);
                    check_field("overflow", want.overflow, i_out_data.overflow);
                    check_field("last", want.last, i_out_data.last);
                end
                checked++;
            end
        end
        o_fail_count     <= misses;
        o_tokens_due     <= tokens_due.size();
        o_tokens_checked <= checked;
    end

endmodule

// ----- tb/c_subset_tokenizer_test.sv -----
`timescale 1ns / 1ps

module c_subset_tokenizer_test;
    import ctok_pkg::*;

    localparam int CYCLE_LIMIT  = 500000;
    localparam int DRAIN_CYCLES = 20;
    localparam int RANDOM_ITEMS = 490;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_ready;
    t_in_item  in_data   = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    t_out_item out_data;

    int fail_count;
    int tokens_due;
    int tokens_checked;
    int cycles      = 0;
    int items_sent  = 0;
    int texts_ended = 0;
    bit gapless     = 1'b0;

    always #1 clk = ~clk;

    c_subset_tokenizer i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    ctok_token_checker i_checker (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .i_in_ready       (in_ready),
        .i_in_data        (in_data),
        .i_out_valid      (out_valid),
        .i_out_ready      (out_ready),
        .i_out_data       (out_data),
        .o_fail_count     (fail_count),
        .o_tokens_due     (tokens_due),
        .o_tokens_checked (tokens_checked)
    );

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Stopped after %0d cycles with %0d tokens still due", cycles, tokens_due);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Token sink: a fresh stall before every transfer, none during gapless stretches.
    initial begin
        int stall;
        wait (rst_n === 1'b1);
        forever begin
            stall = gapless ? 0 : $urandom_range(0, 16);
            if (stall > 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    end

    task automatic send_item(input logic [7:0] code, input bit eot);
        int gap;
        gap = gapless ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= t_in_item'{ch: code, end_of_text: eot};
        do @(posedge clk); while (!in_ready);
        items_sent++;
        if (eot) begin
            texts_ended++;
        end
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            send_item(s[i], 1'b0);
        end
    endtask

    // The byte that rides with an end mark is meaningless, so it is random.
    task automatic end_text();
        send_item(8'($urandom_range(0, 255)), 1'b1);
    endtask

    function automatic logic [7:0] ident_byte(bit first);
        int r;
        r = $urandom_range(0, first ? 52 : 62);
        if (r < 26) begin
            return 8'("a" + r);
        end
        if (r < 52) begin
            return 8'("A" + r - 26);
        end
        if (r == 52) begin
            return "_";
        end
        return 8'("0" + r - 53);
    endfunction

    // One piece of source text: mostly tokens, some blanks and comments, some noise.
    task automatic send_fragment();
        int    pick;
        int    len;
        string word;
        string ops;
        logic [7:0] b;
        ops  = "(){};,=+-*/<>!&|";
        pick = $urandom_range(0, 99);
        if (pick < 15) begin
            case ($urandom_range(0, 4))
                0: word = "int";
                1: word = "return";
                2: word = "if";
                3: word = "else";
                default: word = "while";
            endcase
            // Near misses of a keyword must come out as identifiers.
            if ($urandom_range(0, 3) == 0) begin
                word = word.substr(0, word.len() - 2);
            end
            send_text(word);
            if ($urandom_range(0, 3) == 0) begin
                send_item(ident_byte(1'b0), 1'b0);
            end
        end else if (pick < 30) begin
            len = ($urandom_range(0, 19) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 8);
            send_item(ident_byte(1'b1), 1'b0);
            repeat (len - 1) send_item(ident_byte(1'b0), 1'b0);
        end else if (pick < 44) begin
            repeat ($urandom_range(1, 12)) send_item(8'("0" + $urandom_range(0, 9)), 1'b0);
        end else if (pick < 64) begin
            if ($urandom_range(0, 2) == 0) begin
                case ($urandom_range(0, 5))
                    0: send_text("==");
                    1: send_text("!=");
                    2: send_text("<=");
                    3: send_text(">=");
                    4: send_text("&&");
                    default: send_text("||");
                endcase
            end else begin
                send_item(ops[$urandom_range(0, ops.len() - 1)], 1'b0);
            end
        end else if (pick < 78) begin
            case ($urandom_range(0, 3))
                0: send_text("\n");
                1: send_text("\t");
                default: send_text(" ");
            endcase
        end else if (pick < 84) begin
            send_text("//");
            repeat ($urandom_range(0, 10)) begin
                b = 8'($urandom_range(0, 255));
                send_item((b == "\n") ? 8'(" ") : b, 1'b0);
            end
            send_text("\n");
        end else if (pick < 90) begin
            send_item(8'($urandom_range(0, 255)), 1'b0);
        end else if (pick < 93) begin
            end_text();
        end else begin
            // A lone bang, ampersand or bar followed by something that does not pair.
            case ($urandom_range(0, 2))
                0: send_text("!");
                1: send_text("&");
                default: send_text("|");
            endcase
            send_item(8'($urandom_range(0, 255)), 1'b0);
        end
    endtask

    initial begin
        int random_goal;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Keywords, identifiers, and the text closed right after an identifier.
        send_text("int return if else while _Az9 i9");
        end_text();
        // Every punctuation mark and operator, lone bang, ampersand and bar, unknown bytes.
        send_text("(){};,=+-*/ == != < <= > >= && || ! & | $@ ab");
        send_item(8'hFF, 1'b0);
        send_text("7");
        send_item(8'h80, 1'b0);
        send_text(" 4294967295 4294967296 ");
        repeat (70) send_item("q", 1'b0);
        send_text(" ");
        repeat (66) send_item("9", 1'b0);
        end_text();
        // High byte inside a comment, then the text ends inside a comment.
        send_text("a//x");
        send_item(8'hC3, 1'b0);
        send_text("\n;//c");
        end_text();
        // Held operators flushed by the end mark, and an empty text.
        send_text("!");
        end_text();
        send_text("/");
        end_text();
        send_text(">");
        end_text();
        end_text();
        // The 24-bit offset wrap needs 2^24 bytes in one text, far beyond this run.

        random_goal = items_sent + RANDOM_ITEMS;
        while (items_sent < random_goal) begin
            if ($urandom_range(0, 39) == 0) begin
                gapless = !gapless;
            end
            send_fragment();
        end
        end_text();
        in_valid <= 1'b0;

        do @(posedge clk); while (tokens_due != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Lexed %0d input items over %0d texts and compared %0d tokens.",
                 items_sent, texts_ended, tokens_checked);
        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
